// ===== design/mrpt_pkg.sv =====
// Package for the 64-bit Miller-Rabin prime test: types, witness and limit tables.
// No dependencies.
`default_nettype none
package mrpt_pkg;
   localparam int unsigned DataWidth = 64;
   localparam int unsigned NumWit = 12;
   localparam int unsigned NumLim = 9;

   typedef logic [DataWidth-1:0] word_type;
   typedef logic [3:0] widx_type;
   typedef logic [6:0] bcnt_type;

   // datapath commands
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SHIFT_D,
      CMD_POW_INIT,
      CMD_MUL_START,
      CMD_MUL_STEP,
      CMD_POW_NEXT,
      CMD_SQ_START
   } cmd_type;

   typedef enum logic [1:0] {
      MSEL_ACC_BASE,
      MSEL_BASE_BASE,
      MSEL_X_X
   } msel_type;

   typedef struct packed {
      cmd_type  cmd;
      msel_type msel;
      widx_type wit;
   } ctrl_type;

   typedef struct packed {
      logic     lt2;
      logic     is2;
      logic     even;
      logic     d_odd;
      logic     ex_zero;
      logic     ex_lsb;
      logic     mul_done;
      logic     x_is_one;
      logic     x_is_nm1;
      widx_type wit_count;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLASS, ST_SPLIT, ST_WIT, ST_POW_CHK, ST_POW_MUL, ST_POW_SQ,
      ST_POW_ADV, ST_CHECK, ST_SQ, ST_SQ_CHK, ST_DONE
   } state_type;

   function automatic word_type witness(input widx_type i);
      word_type w;
      case (i)
         4'd0: w = 64'd2;   4'd1: w = 64'd3;   4'd2: w = 64'd5;   4'd3: w = 64'd7;
         4'd4: w = 64'd11;  4'd5: w = 64'd13;  4'd6: w = 64'd17;  4'd7: w = 64'd19;
         4'd8: w = 64'd23;  4'd9: w = 64'd29;  4'd10: w = 64'd31; default: w = 64'd37;
      endcase
      return w;
   endfunction

   // witness count from magnitude thresholds
   function automatic widx_type wit_count(input word_type n);
      widx_type k;
      if (n < 64'd2046) k = 4'd1;
      else if (n < 64'd1373652) k = 4'd2;
      else if (n < 64'd25326000) k = 4'd3;
      else if (n < 64'd3215031750) k = 4'd4;
      else if (n < 64'd2152302898746) k = 4'd5;
      else if (n < 64'd3474749660382) k = 4'd6;
      else if (n < 64'd341550071728320) k = 4'd7;
      else if (n < 64'd3825123056546413050) k = 4'd9;
      else k = 4'd12;
      return k;
   endfunction
endpackage
`default_nettype wire

// ===== design/mrpt_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface mrpt_if #(parameter int unsigned Width = 64) (input wire logic clock);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/mrpt_datapath.sv =====
// Datapath: candidate, exponent, power accumulators and a shift-add modular multiplier.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_datapath (
   input  wire logic              clock,
   input  wire mrpt_pkg::word_type candidate,
   input  wire mrpt_pkg::ctrl_type ctrl,
   output      mrpt_pkg::stat_type stat
);
   import mrpt_pkg::*;

   word_type n_ff, n_in, d_ff, d_in, ex_ff, ex_in;
   word_type acc_ff, acc_in, base_ff, base_in;
   word_type ma_ff, ma_in, mb_ff, mb_in, mr_ff, mr_in;
   word_type nm1;
   logic [DataWidth:0] s1, s2;
   word_type r1, r2;

   assign nm1 = n_ff - 64'd1;

   // modular add with carry-out handling
   always_comb begin
      s1 = {1'b0, mr_ff} + {1'b0, ma_ff};
      r1 = (s1 >= {1'b0, n_ff}) ? DataWidth'(s1 - {1'b0, n_ff}) : s1[DataWidth-1:0];
      s2 = {1'b0, ma_ff} + {1'b0, ma_ff};
      r2 = (s2 >= {1'b0, n_ff}) ? DataWidth'(s2 - {1'b0, n_ff}) : s2[DataWidth-1:0];
   end

   // datapath register update
   always_comb begin
      n_in = n_ff; d_in = d_ff; ex_in = ex_ff; acc_in = acc_ff; base_in = base_ff;
      ma_in = ma_ff; mb_in = mb_ff; mr_in = mr_ff;
      unique case (ctrl.cmd)
         CMD_LOAD: begin
            n_in = candidate;
            d_in = candidate - 64'd1;
         end
         CMD_SHIFT_D: d_in = d_ff >> 1;
         CMD_POW_INIT: begin
            acc_in = 64'd1;
            base_in = witness(ctrl.wit);
            ex_in = d_ff;
         end
         CMD_MUL_START: begin
            mr_in = '0;
            case (ctrl.msel)
               MSEL_ACC_BASE: begin ma_in = base_ff; mb_in = acc_ff; end
               MSEL_BASE_BASE: begin ma_in = base_ff; mb_in = base_ff; end
               default: begin ma_in = acc_ff; mb_in = acc_ff; end
            endcase
         end
         CMD_MUL_STEP: begin
            if (mb_ff[0]) mr_in = r1;
            ma_in = r2;
            mb_in = mb_ff >> 1;
         end
         CMD_POW_NEXT: begin
            case (ctrl.msel)
               MSEL_ACC_BASE: acc_in = mr_ff;
               MSEL_BASE_BASE: begin base_in = mr_ff; ex_in = ex_ff >> 1; end
               default: acc_in = mr_ff;
            endcase
         end
         default: ;
      endcase
   end

   // hold datapath values
   always_ff @(posedge clock) begin
      n_ff <= n_in; d_ff <= d_in; ex_ff <= ex_in; acc_ff <= acc_in; base_ff <= base_in;
      ma_ff <= ma_in; mb_ff <= mb_in; mr_ff <= mr_in;
   end

   assign stat.lt2 = n_ff < 64'd2;
   assign stat.is2 = n_ff == 64'd2;
   assign stat.even = ~n_ff[0];
   assign stat.d_odd = d_ff[0];
   assign stat.ex_zero = ex_ff == '0;
   assign stat.ex_lsb = ex_ff[0];
   assign stat.mul_done = mb_ff == '0;
   assign stat.x_is_one = acc_ff == 64'd1;
   assign stat.x_is_nm1 = acc_ff == nm1;
   assign stat.wit_count = wit_count(n_ff);
endmodule
`default_nettype wire

// ===== design/mrpt_ctrl.sv =====
// Controller FSM sequencing classification, d/r split, witness powers and squarings.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_fire,
   input  wire logic              out_busy,
   output      logic              in_ready,
   output      logic              out_set,
   output      logic              out_flag,
   output      mrpt_pkg::ctrl_type ctrl,
   input  wire mrpt_pkg::stat_type stat
);
   import mrpt_pkg::*;

   state_type state_ff, state_in;
   widx_type wit_ff, wit_in;
   bcnt_type r_ff, r_in, sq_ff, sq_in;
   logic mul_run_ff, mul_run_in, res_ff, res_in;

   // next state
   always_comb begin
      state_in = state_ff; wit_in = wit_ff; r_in = r_ff; sq_in = sq_ff;
      mul_run_in = mul_run_ff; res_in = res_ff;
      unique case (state_ff)
         ST_IDLE: if (in_fire) state_in = ST_CLASS;
         ST_CLASS: begin
            r_in = '0; wit_in = '0;
            if (stat.lt2 || (stat.even && !stat.is2)) begin
               res_in = 1'b0; state_in = ST_DONE;
            end else if (stat.is2) begin
               res_in = 1'b1; state_in = ST_DONE;
            end else state_in = ST_SPLIT;
         end
         ST_SPLIT: if (stat.d_odd) state_in = ST_WIT; else r_in = r_ff + 7'd1;
         ST_WIT: begin
            if (wit_ff == stat.wit_count) begin
               res_in = 1'b1; state_in = ST_DONE;
            end else state_in = ST_POW_CHK;
         end
         ST_POW_CHK: begin
            mul_run_in = 1'b0;
            if (stat.ex_zero) state_in = ST_CHECK;
            else if (stat.ex_lsb) state_in = ST_POW_MUL;
            else state_in = ST_POW_SQ;
         end
         ST_POW_MUL: begin
            mul_run_in = 1'b1;
            if (mul_run_ff && stat.mul_done) begin
               mul_run_in = 1'b0; state_in = ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            mul_run_in = 1'b1;
            if (mul_run_ff && stat.mul_done) begin
               mul_run_in = 1'b0; state_in = ST_POW_CHK;
            end
         end
         ST_CHECK: begin
            sq_in = 7'd1;
            if (stat.x_is_one || stat.x_is_nm1) begin
               wit_in = wit_ff + 4'd1; state_in = ST_WIT;
            end else state_in = ST_SQ;
         end
         ST_SQ: begin
            if (sq_ff >= r_ff) begin
               res_in = 1'b0; state_in = ST_DONE;
            end else begin
               mul_run_in = 1'b1;
               if (mul_run_ff && stat.mul_done) begin
                  mul_run_in = 1'b0; state_in = ST_SQ_CHK;
               end
            end
         end
         ST_SQ_CHK: begin
            if (stat.x_is_nm1) begin
               wit_in = wit_ff + 4'd1; state_in = ST_WIT;
            end else begin
               sq_in = sq_ff + 7'd1; state_in = ST_SQ;
            end
         end
         ST_DONE: if (!out_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl.cmd = CMD_NONE; ctrl.msel = MSEL_ACC_BASE; ctrl.wit = wit_ff;
      in_ready = 1'b0; out_set = 1'b0; out_flag = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_fire) ctrl.cmd = CMD_LOAD;
         end
         ST_SPLIT: if (!stat.d_odd) ctrl.cmd = CMD_SHIFT_D;
         ST_WIT: ctrl.cmd = CMD_POW_INIT;
         ST_POW_MUL, ST_POW_SQ, ST_SQ: begin
            ctrl.msel = (state_ff == ST_POW_MUL) ? MSEL_ACC_BASE :
                        (state_ff == ST_POW_SQ) ? MSEL_BASE_BASE : MSEL_X_X;
            if (!mul_run_ff) ctrl.cmd = CMD_MUL_START;
            else if (!stat.mul_done) ctrl.cmd = CMD_MUL_STEP;
            else ctrl.cmd = CMD_POW_NEXT;
            if (state_ff == ST_SQ && sq_ff >= r_ff) ctrl.cmd = CMD_NONE;
         end
         ST_DONE: out_set = !out_busy;
         default: ;
      endcase
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mul_run_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mul_run_ff <= mul_run_in;
      end
      wit_ff <= wit_in; r_ff <= r_in; sq_ff <= sq_in; res_ff <= res_in;
   end
endmodule
`default_nettype wire

// ===== design/miller_rabin_prime_test_64.sv =====
// Top level of the deterministic 64-bit Miller-Rabin prime test.
// Depends on mrpt_pkg, mrpt_if, mrpt_ctrl and mrpt_datapath.
//
// Usage: a 64-bit candidate item enters on the req channel (valid/ready);
// one 1-bit item leaves on the rsp channel: 1 when the candidate is prime.
// One item is processed at a time. Values below 2 and even values finish
// straight after classification. Odd candidates run up to 12 witnesses;
// each modular power takes up to 126 modular products, each on the single
// shift-add multiplier, plus up to 62 extra squarings. The worst case is
// set by that multiplier.
// The result sits in an output register; a new candidate is accepted once
// the result has been handed to that register, even while rsp is stalled.
// A stalled rsp holds its item and the controller waits in its final state
// only while the output register is still full.
// Reset (synchronous, active high) returns the controller to idle and
// empties the output register.
`default_nettype none
module miller_rabin_prime_test_64 (
   input wire logic clock,
   input wire logic reset,
   mrpt_if.sink     req,
   mrpt_if.source   rsp
);
   import mrpt_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic in_fire, out_set, out_flag, in_ready;
   logic rsp_valid_ff, rsp_valid_in, rsp_flag_ff, rsp_flag_in;

   assign in_fire = req.valid && in_ready;
   assign req.ready = in_ready;

   mrpt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .out_busy(rsp_valid_ff && !rsp.ready),
      .in_ready(in_ready), .out_set(out_set), .out_flag(out_flag), .ctrl(ctrl), .stat(stat)
   );

   mrpt_datapath u_dp (
      .clock(clock), .candidate(req.data), .ctrl(ctrl), .stat(stat)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_flag_in = rsp_flag_ff;
      if (out_set) begin
         rsp_valid_in = 1'b1;
         rsp_flag_in = out_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_flag_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_set |-> !(rsp_valid_ff && !rsp.ready)) else $error("result overwritten");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      in_fire |=> !in_ready) else $error("accepted while busy");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      out_set |=> !out_set) else $error("double result");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the 64-bit Miller-Rabin prime test: directed table plus random candidates.
// Depends on mrpt_pkg, mrpt_if and miller_rabin_prime_test_64.
`timescale 1ns / 1ps
module tb_top;
   import mrpt_pkg::*;

   // Test phases: idling profile for each stretch of stimulus
   typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrpt_if #(.Width(64)) req_ch (clock);
   mrpt_if #(.Width(1))  rsp_ch (clock);

   miller_rabin_prime_test_64 dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Golden verdicts waiting for their rsp items, oldest first
   bit     prime_q[$];
   word_type cand_q[$];
   int     errors = 0;
   int     n_checked = 0;
   int     n_primes = 0;
   int     snk_stall_pct = 0;
   int     long_hold = 0;

   // ---------------- predictor ----------------
   function automatic word_type addm(word_type x, word_type y, word_type m);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[63:0];
   endfunction

   function automatic word_type mulm(word_type x, word_type y, word_type m);
      word_type acc;
      acc = '0;
      x = x % m;
      while (y != 0) begin
         if (y[0]) acc = addm(acc, x, m);
         x = addm(x, x, m);
         y = y >> 1;
      end
      return acc;
   endfunction

   function automatic word_type powm(word_type b, word_type e, word_type m);
      word_type acc;
      acc = 64'd1;
      b = b % m;
      while (e != 0) begin
         if (e[0]) acc = mulm(acc, b, m);
         b = mulm(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic bit predict_prime(word_type n);
      word_type lims[9];
      int       cnts[10];
      word_type wits[12];
      word_type d, x;
      int       r, k, j;
      bit       ok;
      lims = '{64'd2046, 64'd1373652, 64'd25326000, 64'd3215031750,
               64'd2152302898746, 64'd3474749660382, 64'd341550071728320,
               64'd3825123056546413050, 64'hFFFF_FFFF_FFFF_FFFF};
      cnts = '{1, 2, 3, 4, 5, 6, 7, 9, 12, 12};
      wits = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if (!n[0]) return 1'b0;
      j = 0;
      while (j < 9 && n >= lims[j]) j++;
      k = cnts[j];
      d = n - 1;
      r = 0;
      while (!d[0]) begin
         d = d >> 1;
         r++;
      end
      for (int i = 0; i < k; i++) begin
         if (wits[i] % n == 0) continue;
         x = powm(wits[i], d, n);
         if (x == 1 || x == n - 1) continue;
         ok = 1'b0;
         for (int s = 1; s < r; s++) begin
            x = mulm(x, x, n);
            if (x == n - 1) begin
               ok = 1'b1;
               break;
            end
         end
         if (!ok) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   // ---------------- driver ----------------
   phase_type phase = PH_NONE;
   int        src_idle_pct = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
   end

   // Offer one candidate, with optional random idle first; hold until accepted.
   // Valid stays high after the item, until the next offer or the caller drives it low.
   task automatic send_item(input word_type n, input int has_exp, input bit exp_val);
      bit p;
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      p = predict_prime(n);
      if (has_exp && p != exp_val)
         report_mismatch($sformatf("table verdict for %0d disagrees with predictor", n));
      req_ch.valid <= 1'b1;
      req_ch.data  <= n;
      do @(posedge clock); while (!req_ch.ready);
      prime_q.push_back(p);
      cand_q.push_back(n);
      if (p) n_primes++;
   endtask

   // Mostly odd, mostly small magnitudes, some full width
   function automatic word_type rand_cand();
      word_type v;
      int sel;
      v = {$urandom(), $urandom()};
      sel = $urandom_range(9);
      if (sel < 4) v = v & 64'hFFFF_FFFF;
      else if (sel < 6) v = v & 64'hFFFFF;
      else if (sel < 7) v = v & 64'hFF;
      if ($urandom_range(9) < 8) v[0] = 1'b1;
      return v;
   endfunction

   typedef struct {
      word_type n;
      int       has_exp;
      bit       exp_val;
   } row_type;

   row_type dir_tab[] = '{
      '{64'd0, 1, 1'b0}, '{64'd1, 1, 1'b0}, '{64'd2, 1, 1'b1}, '{64'd3, 1, 1'b1},
      '{64'd4, 1, 1'b0}, '{64'd9, 1, 1'b0}, '{64'd37, 1, 1'b1},
      '{64'd2045, 0, 1'b0}, '{64'd2047, 0, 1'b0}, '{64'd1373653, 0, 1'b0},
      '{64'd25326001, 0, 1'b0}, '{64'd3215031751, 0, 1'b0},
      '{64'd2152302898747, 0, 1'b0}, '{64'd3474749660383, 0, 1'b0},
      '{64'd341550071728321, 0, 1'b0}, '{64'd3825123056546413051, 0, 1'b0},
      '{64'd18446744073709551557, 0, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b0}, '{64'hFFFF_FFFF_FFFF_FFFE, 1, 1'b0},
      '{64'h8000_0000_0000_0001, 0, 1'b0}, '{64'd561, 0, 1'b0},
      '{64'hAAAA_AAAA_AAAA_AAAB, 0, 1'b0}, '{64'h5555_5555_5555_5555, 0, 1'b0}
   };

   // Sink: random stalls per phase, plus one long hold-off counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         long_hold <= long_hold - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // Checker: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (prime_q.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            if (rsp_ch.data[0] !== prime_q[0])
               report_mismatch($sformatf("n=%0d got %b want %b",
                                         cand_q[0], rsp_ch.data[0], prime_q[0]));
            void'(prime_q.pop_front());
            void'(cand_q.pop_front());
            n_checked++;
         end
      end
   end

   task automatic set_phase(input phase_type ph);
      phase = ph;
      src_idle_pct  = (ph == PH_SRC) ? 55 : (ph == PH_BOTH) ? 13 : 0;
      snk_stall_pct = (ph == PH_SNK) ? 55 : (ph == PH_BOTH) ? 13 : 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_phase(PH_NONE);
      foreach (dir_tab[i]) send_item(dir_tab[i].n, dir_tab[i].has_exp, dir_tab[i].exp_val);
      // hold the receiver off while quick candidates keep coming, so the block fills
      long_hold = 3000;
      for (int i = 0; i < 6; i++) send_item(rand_cand() & 64'hFF, 0, 1'b0);
      // pause until everything has drained
      req_ch.valid <= 1'b0;
      wait (prime_q.size() == 0);
      for (int p = 0; p < 4; p++) begin
         set_phase(phase_type'(p));
         for (int i = 0; i < 18; i++) send_item(rand_cand(), 0, 1'b0);
      end
      req_ch.valid <= 1'b0;
      set_phase(PH_NONE);
      wait (prime_q.size() == 0);
      repeat (50) @(posedge clock);
      $display("checked %0d results over four idling profiles, %0d prime verdicts",
               n_checked, n_primes);
      if (errors == 0 && prime_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Run limit: the worst case per item, ~100 items, taken many times over
   initial begin
      #400_000_000;
      $display("timeout");
      $display("CHECK FAILED");
      $finish;
   end
endmodule
